// File: rtl/core/pcs_pkg.sv
// pcs_pkg: shared types and constants for the prime count sieve.
// No dependencies; imported by the sieve controller and the top level.
`timescale 1ns / 1ps

package pcs_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned LimitW = 11;
  localparam int unsigned CountW = 11;

  // Smallest limit that can hold a prime below it
  localparam int unsigned FirstPrime = 2;
  localparam int unsigned MinLimit   = 3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_TEST,
    ST_MARK,
    ST_NEXT,
    ST_DONE
  } pcs_state_e;

endpackage

// File: rtl/core/pcs_map.sv
// pcs_map: one-bit-per-number composite bitmap for the sieve.
// One write port and one read port with registered read data; no dependencies.
`timescale 1ns / 1ps

module pcs_map #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic map_q [Depth];
  logic rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      map_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= map_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pcs_alu.sv
// pcs_alu: the single shared adder and limit compare used by the sieve.
// Computes a + b and flags whether the sum is still below the limit. No dependencies.
`timescale 1ns / 1ps

module pcs_alu #(
  parameter int unsigned NumW = 11,
  parameter int unsigned SumW = NumW + 1
) (
  input  logic [SumW-1:0] a_i,
  input  logic [SumW-1:0] b_i,
  input  logic [NumW-1:0] limit_i,
  output logic [SumW-1:0] sum_o,
  output logic            below_o
);

  // Shared add, then compare against the active limit
  assign sum_o   = a_i + b_i;
  assign below_o = (sum_o < SumW'(limit_i));

endmodule

// File: rtl/core/pcs_ctrl.sv
// pcs_ctrl: sequencer for the sieve: clears the bitmap, scans candidates,
// counts primes and marks multiples. Uses pcs_pkg and pcs_alu.
`timescale 1ns / 1ps

module pcs_ctrl
  import pcs_pkg::*;
#(
  parameter int unsigned MaxLimit = 1024,
  parameter int unsigned AddrW    = (MaxLimit > 1) ? $clog2(MaxLimit) : 1,
  parameter int unsigned NumW     = ($clog2(MaxLimit + 1) > LimitW) ?
                                    $clog2(MaxLimit + 1) : LimitW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LimitW-1:0] limit_n_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [CountW-1:0] prime_count_o,
  output logic              map_we_o,
  output logic [AddrW-1:0]  map_waddr_o,
  output logic              map_wdata_o,
  output logic [AddrW-1:0]  map_raddr_o,
  input  logic              map_rdata_i
);

  localparam int unsigned SumW = NumW + 1;

  pcs_state_e state_q, state_d;
  logic [NumW-1:0] n_q, n_d;
  logic [NumW-1:0] i_q, i_d;
  logic [SumW-1:0] j_q, j_d;
  logic [NumW-1:0] count_q, count_d;

  logic [NumW-1:0] limit_ext;
  logic [NumW-1:0] limit_sat;
  logic [SumW-1:0] alu_a, alu_b, alu_sum;
  logic            alu_below;

  // Clamp the requested limit to the bitmap size
  assign limit_ext = NumW'(limit_n_i);
  assign limit_sat = (limit_ext > NumW'(MaxLimit)) ? NumW'(MaxLimit) : limit_ext;

  pcs_alu #(
    .NumW (NumW),
    .SumW (SumW)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .limit_i (n_q),
    .sum_o   (alu_sum),
    .below_o (alu_below)
  );

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    j_q     <= j_d;
    count_q <= count_d;
  end

  // Next state, shared adder operands and bitmap accesses
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    count_d     = count_q;
    alu_a       = SumW'(i_q);
    alu_b       = SumW'(1);
    map_we_o    = 1'b0;
    map_waddr_o = i_q[AddrW-1:0];
    map_wdata_o = 1'b0;
    map_raddr_o = i_q[AddrW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          n_d     = limit_sat;
          i_d     = NumW'(FirstPrime);
          count_d = '0;
          state_d = (limit_sat < NumW'(MinLimit)) ? ST_DONE : ST_CLEAR;
        end
      end
      // Mark 2 .. n-1 as prime, one entry a cycle
      ST_CLEAR: begin
        map_we_o = 1'b1;
        i_d      = alu_sum[NumW-1:0];
        if (!alu_below) begin
          i_d     = NumW'(FirstPrime);
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_TEST;
      end
      // Unmarked candidate is prime: count it and start marking at 2i
      ST_TEST: begin
        if (map_rdata_i) begin
          state_d = ST_NEXT;
        end else begin
          count_d = count_q + NumW'(1);
          alu_b   = SumW'(i_q);
          j_d     = alu_sum;
          state_d = alu_below ? ST_MARK : ST_NEXT;
        end
      end
      ST_MARK: begin
        map_we_o    = 1'b1;
        map_waddr_o = j_q[AddrW-1:0];
        map_wdata_o = 1'b1;
        alu_a       = j_q;
        alu_b       = SumW'(i_q);
        j_d         = alu_sum;
        if (!alu_below) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        i_d     = alu_sum[NumW-1:0];
        state_d = alu_below ? ST_READ : ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_DONE);
  assign prime_count_o = count_q[CountW-1:0];

`ifndef SYNTHESIS
  // The result strobe lasts one cycle and frees the block
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("result strobe not followed by idle");

  // Small limits answer right away
  a_small_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (limit_n_i < LimitW'(MinLimit))) |=> done_o)
    else $error("small limit did not finish at once");

  // Marking writes stay inside the active range
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK) |-> (map_we_o && (j_q < SumW'(n_q))))
    else $error("marking write outside the limit");

  // Candidate never reaches the limit while scanning
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) || (state_q == ST_TEST)) |-> (i_q < n_q))
    else $error("scan index reached the limit");
`endif

endmodule

// File: rtl/core/prime_count_sieve.sv
// Prime count sieve: counts the primes strictly below a requested limit with a
// Sieve of Eratosthenes over a one-bit bitmap. An item is taken when start_i is
// high and busy_o is low; busy_o stays high until the result is shown. The count
// appears on prime_count_o for exactly one cycle with done_o high, and the
// receiver cannot stall it. Limits above MAX_LIMIT are clamped to MAX_LIMIT and
// limits below 3 return zero, going from idle straight to the done state.
// Otherwise, for clamped limit n, it clears bitmap entries 2 to n-1, then
// tests each candidate from 2 to n-1, counting each unmarked one as a prime
// and marking its multiples below n, from twice the prime. Run time is set by
// the single shared adder and the one write and one read port of the bitmap:
// one bitmap access per cycle. Uses pcs_pkg, pcs_ctrl, pcs_alu and pcs_map.
`timescale 1ns / 1ps

module prime_count_sieve
  import pcs_pkg::*;
#(
  parameter int unsigned MAX_LIMIT = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LimitW-1:0] limit_n_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [CountW-1:0] prime_count_o
);

  localparam int unsigned AddrW = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;

  logic             map_we;
  logic [AddrW-1:0] map_waddr;
  logic             map_wdata;
  logic [AddrW-1:0] map_raddr;
  logic             map_rdata;

  // Sequencer with the shared adder
  pcs_ctrl #(
    .MaxLimit (MAX_LIMIT),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .limit_n_i     (limit_n_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .prime_count_o (prime_count_o),
    .map_we_o      (map_we),
    .map_waddr_o   (map_waddr),
    .map_wdata_o   (map_wdata),
    .map_raddr_o   (map_raddr),
    .map_rdata_i   (map_rdata)
  );

  // Composite bitmap
  pcs_map #(
    .Depth (MAX_LIMIT),
    .AddrW (AddrW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

endmodule
